@@ src/jet_pkg.sv @@
// Shared constants and types for the escape-time iterator.
// Used by jet_mul, julia_escape_time_iterator and jet_chk; no dependencies.
`timescale 1ns / 1ps

package jet_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int CHUNK_W        = 32;
    localparam int FIELD_W        = 32;
    localparam int LIMIT_W        = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_DATA_W      = 2 * FIELD_W;
    localparam int OUT_DATA_W     = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL = 2'd0,
        CFG_C_IMAG = 2'd1,
        CFG_LIMIT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic start;
        logic dbl;
    } mul_ctl_t;

endpackage

@@ src/julia_escape_time_iterator.sv @@
// Julia-set escape-time iterator: z = z*z + c from z0 until |z|^2 > 4 or the limit.
// Top level; depends on jet_pkg and jet_mul.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tdata: start_real [31:0], start_imag [63:32]
//  m_axis    | out       | tdata: iteration_count [9:0], zeros above
//  cfg       | in        | cfg_index 0 c_real, 1 c_imag, 2 iteration_limit
//
// Each multiply runs on the shared unit, which forms N*N chunk products, N = ceil(WORD_WIDTH/32);
// one iteration is three multiplies plus three add/check states.
// An item squares z0, runs that loop until it escapes or reaches the limit, then emits its count;
// a zero limit goes from the accept straight to the emit state.
// s_axis_tready is high only while idle; a finished count waits in the output register.
// Reset is asynchronous, active low; the limit resets to 100 and c to zero.
`timescale 1ns / 1ps

module julia_escape_time_iterator #(
    parameter int WORD_WIDTH = jet_pkg::WORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [jet_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // start_real, start_imag
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [jet_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // iteration_count, zero pad
    input  logic                              cfg_we,
    input  logic [jet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jet_pkg::FIELD_W-1:0]       cfg_data
);

    localparam int W  = WORD_WIDTH;
    localparam int FW = jet_pkg::FIELD_W;
    localparam int LW = jet_pkg::LIMIT_W;

    localparam logic signed [W-1:0] FOUR = {2'b01, {(W-2){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_I,
        ST_MUL_RI,
        ST_UPD_A,
        ST_UPD_B,
        ST_SQ_R2,
        ST_SQ_I2,
        ST_CHECK,
        ST_EMIT
    } state_t;

    function automatic logic [W-1:0] sat_fold(input logic [W:0] s);
        logic [W-1:0] r;
        if (s[W] != s[W-1])
        begin
            r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            r = s[W-1:0];
        end
        return r;
    endfunction

    state_t                state_reg;
    logic                  pend_reg;
    logic [W-1:0]          zr_reg;
    logic [W-1:0]          zi_reg;
    logic [W-1:0]          rr_reg;
    logic [W-1:0]          ii_reg;
    logic [W-1:0]          ri_reg;
    logic [LW-1:0]         count_reg;
    logic                  out_valid_reg;
    logic [LW-1:0]         out_data_reg;
    logic [FW-1:0]         c_real_reg;
    logic [FW-1:0]         c_imag_reg;
    logic [LW-1:0]         limit_reg;

    jet_pkg::mul_ctl_t     mul_ctl;
    logic signed [W-1:0]   mul_a;
    logic signed [W-1:0]   mul_b;
    logic                  mul_done;
    logic signed [W-1:0]   mul_result;

    logic [W-1:0]          cr;
    logic [W-1:0]          ci;
    logic [W-1:0]          diff_sat;
    logic [W-1:0]          ni_sat;
    logic [W-1:0]          nr_sat;
    logic [W-1:0]          mag_sat;
    logic [LW-1:0]         count_inc;
    logic                  is_mul_state;
    logic                  out_free;

    assign cr = W'(c_real_reg);
    assign ci = W'(c_imag_reg);

    assign diff_sat = sat_fold({rr_reg[W-1], rr_reg} - {ii_reg[W-1], ii_reg});
    assign ni_sat   = sat_fold({ri_reg[W-1], ri_reg} + {ci[W-1], ci});
    assign nr_sat   = sat_fold({rr_reg[W-1], rr_reg} + {cr[W-1], cr});
    assign mag_sat  = sat_fold({rr_reg[W-1], rr_reg} + {ii_reg[W-1], ii_reg});

    assign count_inc = count_reg + LW'(1);
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        case (state_reg)
            ST_SQ_R, ST_SQ_R2:
            begin
                mul_a        = zr_reg;
                mul_b        = zr_reg;
                is_mul_state = 1'b1;
            end
            ST_SQ_I, ST_SQ_I2:
            begin
                mul_a        = zi_reg;
                mul_b        = zi_reg;
                is_mul_state = 1'b1;
            end
            ST_MUL_RI:
            begin
                mul_a        = zr_reg;
                mul_b        = zi_reg;
                is_mul_state = 1'b1;
            end
            default:
            begin
                mul_a        = zr_reg;
                mul_b        = zi_reg;
                is_mul_state = 1'b0;
            end
        endcase
    end

    assign mul_ctl.start = is_mul_state && !pend_reg;
    assign mul_ctl.dbl   = (state_reg == ST_MUL_RI);

    jet_mul #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg <= '0;
            c_imag_reg <= '0;
            limit_reg  <= jet_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (jet_pkg::cfg_index_t'(cfg_index))
                jet_pkg::CFG_C_REAL: c_real_reg <= cfg_data;
                jet_pkg::CFG_C_IMAG: c_imag_reg <= cfg_data;
                jet_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[LW-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            zr_reg        <= '0;
            zi_reg        <= '0;
            rr_reg        <= '0;
            ii_reg        <= '0;
            ri_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            if (mul_done)
            begin
                pend_reg <= 1'b0;
            end
            else if (mul_ctl.start)
            begin
                pend_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        zr_reg    <= W'(s_axis_tdata[FW-1:0]);
                        zi_reg    <= W'(s_axis_tdata[2*FW-1:FW]);
                        count_reg <= '0;
                        state_reg <= (limit_reg == '0) ? ST_EMIT : ST_SQ_R;
                    end
                end
                ST_SQ_R:
                begin
                    if (mul_done)
                    begin
                        rr_reg    <= mul_result;
                        state_reg <= ST_SQ_I;
                    end
                end
                ST_SQ_I:
                begin
                    if (mul_done)
                    begin
                        ii_reg    <= mul_result;
                        state_reg <= ST_MUL_RI;
                    end
                end
                ST_MUL_RI:
                begin
                    if (mul_done)
                    begin
                        ri_reg    <= mul_result;
                        state_reg <= ST_UPD_A;
                    end
                end
                ST_UPD_A:
                begin
                    rr_reg    <= diff_sat;
                    zi_reg    <= ni_sat;
                    state_reg <= ST_UPD_B;
                end
                ST_UPD_B:
                begin
                    zr_reg    <= nr_sat;
                    state_reg <= ST_SQ_R2;
                end
                ST_SQ_R2:
                begin
                    if (mul_done)
                    begin
                        rr_reg    <= mul_result;
                        state_reg <= ST_SQ_I2;
                    end
                end
                ST_SQ_I2:
                begin
                    if (mul_done)
                    begin
                        ii_reg    <= mul_result;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if ($signed(mag_sat) > FOUR)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        count_reg <= count_inc;
                        state_reg <= (count_inc == limit_reg) ? ST_EMIT : ST_MUL_RI;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = jet_pkg::OUT_DATA_W'(out_data_reg);

endmodule

@@ src/jet_mul.sv @@
// Shared fixed-point multiplier: magnitude product built from chunk products
// one at a time, then floor shift by F or F-1 and saturation.
// Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_mul #(
    parameter int WORD_WIDTH = jet_pkg::WORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jet_pkg::mul_ctl_t            ctl,
    input  logic signed [WORD_WIDTH-1:0] a,
    input  logic signed [WORD_WIDTH-1:0] b,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] result
);

    localparam int W    = WORD_WIDTH;
    localparam int F    = W - 4;
    localparam int CW   = jet_pkg::CHUNK_W;
    localparam int N    = (W + CW - 1) / CW;
    localparam int MW   = N * CW;
    localparam int IDXW = (N > 1) ? $clog2(N) : 1;

    localparam logic [2*W-1:0] MASK_F   = {{(2*W-F){1'b0}}, {F{1'b1}}};
    localparam logic [2*W-1:0] MASK_D   = {{(2*W-F+1){1'b0}}, {(F-1){1'b1}}};
    localparam logic [2*W-1:0] POS_LIM  = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [2*W-1:0] NEG_LIM  = {{(W+1){1'b0}}, 1'b1, {(W-2){1'b0}}} << 1;
    localparam logic [W-1:0]   WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   WORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_ADD,
        M_FIN
    } mstate_t;

    mstate_t                    state_reg;
    logic [N-1:0][CW-1:0]       a_mag_reg;
    logic [N-1:0][CW-1:0]       b_mag_reg;
    logic                       neg_reg;
    logic                       dbl_reg;
    logic [IDXW-1:0]            i_reg;
    logic [IDXW-1:0]            j_reg;
    logic [2*CW-1:0]            pp_reg;
    logic [2*MW-1:0]            acc_reg;
    logic                       done_reg;
    logic [W-1:0]               result_reg;

    logic [W-1:0]     a_abs;
    logic [W-1:0]     b_abs;
    logic [2*MW-1:0]  pp_shifted;
    logic [2*W-1:0]   uprod;
    logic [2*W-1:0]   quot;
    logic [2*W-1:0]   quot_up;
    logic             rem_nz;
    logic [W-1:0]     fin_value;

    assign a_abs = a[W-1] ? (~a + W'(1)) : a;
    assign b_abs = b[W-1] ? (~b + W'(1)) : b;

    assign pp_shifted = (2*MW)'(pp_reg) << (CW * (int'(i_reg) + int'(j_reg)));

    assign uprod   = acc_reg[2*W-1:0];
    assign quot    = dbl_reg ? (uprod >> (F - 1)) : (uprod >> F);
    assign rem_nz  = dbl_reg ? |(uprod & MASK_D) : |(uprod & MASK_F);
    assign quot_up = quot + (2*W)'(neg_reg & rem_nz);

    always_comb
    begin
        if (!neg_reg)
        begin
            fin_value = (quot > POS_LIM) ? WORD_MAX : quot[W-1:0];
        end
        else
        begin
            fin_value = (quot_up > NEG_LIM) ? WORD_MIN : (~quot_up[W-1:0] + W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            done_reg   <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            a_mag_reg  <= '0;
            b_mag_reg  <= '0;
            neg_reg    <= 1'b0;
            dbl_reg    <= 1'b0;
            pp_reg     <= '0;
            acc_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (ctl.start)
                    begin
                        a_mag_reg <= MW'(a_abs);
                        b_mag_reg <= MW'(b_abs);
                        neg_reg   <= a[W-1] ^ b[W-1];
                        dbl_reg   <= ctl.dbl;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    pp_reg    <= a_mag_reg[i_reg] * b_mag_reg[j_reg];
                    state_reg <= M_ADD;
                end
                M_ADD:
                begin
                    acc_reg <= acc_reg + pp_shifted;
                    if (j_reg == IDXW'(N - 1))
                    begin
                        j_reg <= '0;
                        if (i_reg == IDXW'(N - 1))
                        begin
                            state_reg <= M_FIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDXW'(1);
                            state_reg <= M_MUL;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + IDXW'(1);
                        state_reg <= M_MUL;
                    end
                end
                M_FIN:
                begin
                    result_reg <= fin_value;
                    done_reg   <= 1'b1;
                    state_reg  <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/jet_chk.sv @@
// Port-level checks for julia_escape_time_iterator, attached by bind.
// Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [jet_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped or changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input ready while an item is in progress");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after input transfer");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[jet_pkg::OUT_DATA_W-1:jet_pkg::LIMIT_W] == '0)
        else $error("output pad bits not zero");

endmodule

bind julia_escape_time_iterator jet_chk u_jet_chk (.*);

@@ tb/sv/tb_julia_escape_time_iterator.sv @@
// Self-checking bench for julia_escape_time_iterator: drives z0 points over s_axis,
// checks every iteration count on m_axis against its own fixed-point model of z*z + c.
// Depends on jet_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_julia_escape_time_iterator;

    localparam int          FRAC          = 28;
    localparam longint      WORD_MAX      = (longint'(1) << 31) - 1;
    localparam longint      WORD_MIN      = -(longint'(1) << 31);
    localparam longint      FOUR_Q        = longint'(1) << (FRAC + 2);
    localparam logic [31:0] Q_ZERO        = 32'h0000_0000;
    localparam logic [31:0] Q_HALF        = 32'h0800_0000;
    localparam logic [31:0] Q_NEG_HALF    = 32'hF800_0000;
    localparam logic [31:0] Q_ONE         = 32'h1000_0000;
    localparam logic [31:0] Q_NEG_ONE     = 32'hF000_0000;
    localparam logic [31:0] Q_TWO         = 32'h2000_0000;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;
    localparam logic [31:0] Q_LSB         = 32'h0000_0001;
    localparam logic [31:0] Q_NEG_LSB     = 32'hFFFF_FFFF;
    localparam int          PHASES        = 16;
    localparam int          PHASE_ITEMS   = 28;
    localparam int          HOLD_CYCLES   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 60;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    class escape_count_board;
        logic [31:0]                 c_re;
        logic [31:0]                 c_im;
        logic [jet_pkg::LIMIT_W-1:0] limit;
        logic [jet_pkg::LIMIT_W-1:0] counts_due[$];
        int                          errors;

        function new();
            c_re   = Q_ZERO;
            c_im   = Q_ZERO;
            limit  = jet_pkg::LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_reg(input jet_pkg::cfg_index_t idx, input logic [31:0] value);
            case (idx)
                jet_pkg::CFG_C_REAL: c_re  = value;
                jet_pkg::CFG_C_IMAG: c_im  = value;
                jet_pkg::CFG_LIMIT:  limit = value[jet_pkg::LIMIT_W-1:0];
                default:             ;
            endcase
        endfunction

        function longint clamp_word(input longint v);
            if (v > WORD_MAX)
                return WORD_MAX;
            if (v < WORD_MIN)
                return WORD_MIN;
            return v;
        endfunction

        function longint fx_mul(input longint a, input longint b, input int sh);
            return clamp_word((a * b) >>> sh);
        endfunction

        function logic [jet_pkg::LIMIT_W-1:0] escape_count(input logic [31:0] re,
                                                           input logic [31:0] im);
            longint zr, zi, cr, ci, rr, ii, ri;
            int     n;
            zr = longint'($signed(re));
            zi = longint'($signed(im));
            cr = longint'($signed(c_re));
            ci = longint'($signed(c_im));
            n  = 0;
            while (n < int'(limit))
            begin
                rr = fx_mul(zr, zr, FRAC);
                ii = fx_mul(zi, zi, FRAC);
                ri = fx_mul(zr, zi, FRAC - 1);
                zr = clamp_word(clamp_word(rr - ii) + cr);
                zi = clamp_word(ri + ci);
                if (clamp_word(fx_mul(zr, zr, FRAC) + fx_mul(zi, zi, FRAC)) > FOUR_Q)
                    break;
                n++;
            end
            return jet_pkg::LIMIT_W'(n);
        endfunction

        function void note_point(input logic [31:0] re, input logic [31:0] im);
            counts_due.push_back(escape_count(re, im));
        endfunction

        function void check_count(input logic [jet_pkg::LIMIT_W-1:0] got);
            logic [jet_pkg::LIMIT_W-1:0] want;
            if (counts_due.size() == 0)
            begin
                $error("iteration_count: expected none, got %0d", got);
                errors++;
            end
            else
            begin
                want = counts_due.pop_front();
                if (want !== got)
                begin
                    $error("iteration_count: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return counts_due.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [jet_pkg::IN_DATA_W-1:0]    s_axis_tdata;   // start_real, start_imag
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [jet_pkg::OUT_DATA_W-1:0]   m_axis_tdata;   // iteration_count, zero pad
    logic                             cfg_we;
    logic [jet_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [jet_pkg::FIELD_W-1:0]      cfg_data;

    escape_count_board board = new();
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_flip;

    julia_escape_time_iterator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 32'($urandom_range(0, 32'h4000_0000)) - Q_TWO;
        if (sel < 85)
            return $urandom();
        case ($urandom_range(6))
            0:       return Q_ZERO;
            1:       return Q_MAX;
            2:       return Q_MIN;
            3:       return Q_ONE;
            4:       return Q_NEG_ONE;
            5:       return Q_LSB;
            default: return Q_NEG_LSB;
        endcase
    endfunction

    function automatic logic [31:0] pick_const();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 32'($urandom_range(0, 32'h2000_0000)) - Q_ONE;
        if (sel < 85)
            return 32'($urandom_range(0, 32'h4000_0000)) - Q_TWO;
        return $urandom();
    endfunction

    task automatic write_reg(input jet_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_reg(idx, value);
    endtask

    task automatic load_julia(input logic [31:0] cr, input logic [31:0] ci,
                              input logic [jet_pkg::LIMIT_W-1:0] lim);
        write_reg(jet_pkg::CFG_C_REAL, cr);
        write_reg(jet_pkg::CFG_C_IMAG, ci);
        write_reg(jet_pkg::CFG_LIMIT, 32'(lim));
        cfg_we <= 1'b0;
    endtask

    task automatic offer_point(input logic [31:0] re, input logic [31:0] im);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_point(re, im);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: check each transfer, then decide tready for the next edge.
    initial
    begin
        int   hold_left;
        logic hold_seen;
        hold_left     = 0;
        hold_seen     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_count(m_axis_tdata[jet_pkg::LIMIT_W-1:0]);
            if (hold_flip != hold_seen)
            begin
                hold_seen = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_we         = 1'b0;
        cfg_index      = jet_pkg::CFG_C_REAL;
        cfg_data       = '0;
        hold_flip      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: c = 0, limit 100.
        offer_point(Q_HALF, Q_HALF);
        offer_point(Q_MAX, Q_MIN);
        settle();

        // Largest limit: bounded points run the full 1023 updates.
        load_julia(Q_ZERO, Q_ZERO, 10'd1023);
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(Q_NEG_HALF, Q_ZERO);
        offer_point(Q_MIN, Q_MIN);
        offer_point(Q_MAX, Q_ZERO);
        offer_point(Q_ZERO, Q_MAX);
        settle();

        // Zero limit gives a count of zero at once.
        load_julia(Q_ZERO, Q_ZERO, 10'd0);
        offer_point(Q_ONE, Q_ONE);
        offer_point(Q_ZERO, Q_ZERO);
        settle();

        // c = 2: from z0 = 0 the first update lands exactly on |z|^2 = 4, which does not escape.
        load_julia(Q_TWO, Q_ZERO, 10'd5);
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(Q_ZERO, Q_ONE);
        settle();

        // Extreme c saturates the sums.
        load_julia(Q_MIN, Q_MAX, 10'd3);
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(Q_NEG_LSB, Q_LSB);
        settle();

        load_julia(32'hF333_3334, 32'h027E_F9DB, 10'd64);
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(32'h0400_0000, 32'hFC00_0000);
        offer_point(Q_NEG_ONE, Q_ZERO);
        offer_point(32'h0CCC_CCCD, 32'h0333_3333);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            load_julia(pick_const(), pick_const(),
                       jet_pkg::LIMIT_W'($urandom_range(1, 48)));
            // Hold the output side off so the block fills and stalls its input.
            if (phase == 0)
                hold_flip <= ~hold_flip;
            for (int k = 0; k < PHASE_ITEMS; k++)
                offer_point(pick_coord(), pick_coord());
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
